// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands shared by the checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared types, constants and tables of the space vector pwm duty generator
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int DUTY_BITS_DEF     = 16;

  localparam logic [6:0] POLE_PAIRS_RST = 7'd7;

  // cordic datapath width, q1.30 with headroom
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [16:0] K_0866 = 17'd56754;
  localparam logic [16:0] K_1732 = 17'd113508;

  localparam int CS_W  = 32;  // sine, cosine
  localparam int P_W   = 48;  // park products
  localparam int UXY_W = 35;  // ux, uy
  localparam int U_W   = 37;  // phase voltages
  localparam int TV_W  = 37;  // magnitude picked for tx, ty

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] r;
  } cordic_t;

  typedef struct packed {
    logic [2:0] sector;
    logic       zero_vec;
    logic       udc_zero;
  } side_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // sign code {u3>0, u2>0, u1>0} to sector, zero marks the zero vector
  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd6;
      3'd3:    s = 3'd1;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd3;
      3'd6:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/svpwm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// svpwm_cordic_cell
// one registered cordic rotation stage
// ----------------------------------------------------------------------------
module svpwm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               ce,
  input  svpwm_pkg::cordic_t din,
  output svpwm_pkg::cordic_t dout
);

  logic signed [svpwm_pkg::CW-1:0] dx, dy, at;
  svpwm_pkg::cordic_t dout_next;

  always_comb begin
    dx = din.y >>> STAGE;
    dy = din.x >>> STAGE;
    at = $signed({2'b00, svpwm_pkg::atan_turn(5'(STAGE))});
    if (din.r >= 0) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.r = din.r - at;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.r = din.r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== rtl/core/svpwm_div_cell.sv =====
// ----------------------------------------------------------------------------
// svpwm_div_cell
// one registered restoring division step, one quotient bit
// ----------------------------------------------------------------------------
module svpwm_div_cell #(
  parameter int QW = 38
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [15:0]   den_in,
  input  logic [15:0]   rem_in,
  input  logic [QW-1:0] nq_in,
  output logic [15:0]   den_out,
  output logic [15:0]   rem_out,
  output logic [QW-1:0] nq_out
);

  logic [16:0] r2, r2_sub;
  logic        ge;

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    r2     = {rem_in, nq_in[QW-1]};
    ge     = r2 >= {1'b0, den_in};
    r2_sub = r2 - {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      den_out <= den_in;
      rem_out <= ge ? r2_sub[15:0] : r2[15:0];
      nq_out  <= {nq_in[QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/svpwm_duty_generator_core.sv =====
// ----------------------------------------------------------------------------
// svpwm_duty_generator_core
// electrical angle, cordic sine/cosine, inverse park/clarke, sector and
// seven-segment duties in a fully pipelined datapath
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       mech_angle, volt_d, volt_q, bus_voltage
// m_*       out  m_tvalid / m_tready       duty_a/b/c, sector, saturated
// cfg_*     in   cfg_valid / cfg_ready     pole_pairs
//
// one transfer per cycle in and out while not stalled; the depth is set by
// the cordic cell row and the one-bit-per-cell divider row
// the whole pipeline advances together; it stalls only while a result sits
// in the output register and m_tready is low
// rst clears the valid bits and pole_pairs (7); no clearing pass
// ----------------------------------------------------------------------------
module svpwm_duty_generator_core #(
  parameter int ANGLE_BITS    = svpwm_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = svpwm_pkg::CORDIC_STAGES_DEF,
  parameter int DUTY_BITS     = svpwm_pkg::DUTY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // mech_angle, volt_d, volt_q, bus_voltage
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // duty_a, duty_b, duty_c, sector, saturated, zero pad
);

  localparam int NS    = CORDIC_STAGES;
  localparam int QW    = DUTY_BITS + 22;
  localparam int TW    = QW + 3;
  localparam int DEPTH = NS + QW + 11;
  localparam int SH_R  = (DUTY_BITS >= 16) ? DUTY_BITS - 16 : 0;
  localparam int SH_L  = (DUTY_BITS < 16) ? 16 - DUTY_BITS : 0;
  localparam logic [31:0] AMASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< DUTY_BITS;

  logic             ce;
  logic [6:0]       pole_pairs;
  logic [DEPTH-1:0] vld;

  assign ce        = !m_tvalid || m_tready;
  assign s_tready  = ce;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= svpwm_pkg::POLE_PAIRS_RST;
      vld        <= '0;
    end else begin
      if (cfg_valid) begin
        pole_pairs <= cfg_data;
      end
      if (ce) begin
        vld <= {vld[DEPTH-2:0], s_tvalid};
      end
    end
  end

  // electrical angle
  logic [22:0]        theta_prod;
  logic [15:0]        theta1, udc1;
  logic signed [15:0] vd1, vq1;

  assign theta_prod = s_tdata[15:0] * pole_pairs;

  always_ff @(posedge clk) begin
    if (ce) begin
      theta1 <= theta_prod[15:0];
      vd1    <= s_tdata[31:16];
      vq1    <= s_tdata[47:32];
      udc1   <= s_tdata[63:48];
    end
  end

  // fold to +-45 degrees and a quarter count
  logic [31:0] z, zq, rw;

  svpwm_pkg::cordic_t cd [0:NS];
  logic [1:0]         q_d   [0:NS];
  logic signed [15:0] vd_d  [0:NS];
  logic signed [15:0] vq_d  [0:NS];
  logic [15:0]        udc_d [0:NS];

  always_comb begin
    z  = {theta1, 16'h0} & AMASK;
    zq = z + 32'h2000_0000;
    rw = z - {zq[31:30], 30'h0};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cd[0].x  <= svpwm_pkg::CORDIC_X0;
      cd[0].y  <= '0;
      cd[0].r  <= svpwm_pkg::CW'($signed(rw));
      q_d[0]   <= zq[31:30];
      vd_d[0]  <= vd1;
      vq_d[0]  <= vq1;
      udc_d[0] <= udc1;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    svpwm_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .ce   (ce),
      .din  (cd[i]),
      .dout (cd[i+1])
    );

    always_ff @(posedge clk) begin
      if (ce) begin
        q_d[i+1]   <= q_d[i];
        vd_d[i+1]  <= vd_d[i];
        vq_d[i+1]  <= vq_d[i];
        udc_d[i+1] <= udc_d[i];
      end
    end
  end

  // quadrant restore
  logic signed [svpwm_pkg::CW-1:0]   xf, yf, nxf, nyf;
  logic signed [svpwm_pkg::CS_W-1:0] c3, s3;
  logic signed [15:0]                vd3, vq3;
  logic [15:0]                       udc3;

  assign xf  = cd[NS].x;
  assign yf  = cd[NS].y;
  assign nxf = -xf;
  assign nyf = -yf;

  always_ff @(posedge clk) begin
    if (ce) begin
      case (q_d[NS])
        2'd0: begin
          c3 <= xf[svpwm_pkg::CS_W-1:0];
          s3 <= yf[svpwm_pkg::CS_W-1:0];
        end
        2'd1: begin
          c3 <= nyf[svpwm_pkg::CS_W-1:0];
          s3 <= xf[svpwm_pkg::CS_W-1:0];
        end
        2'd2: begin
          c3 <= nxf[svpwm_pkg::CS_W-1:0];
          s3 <= nyf[svpwm_pkg::CS_W-1:0];
        end
        default: begin
          c3 <= yf[svpwm_pkg::CS_W-1:0];
          s3 <= nxf[svpwm_pkg::CS_W-1:0];
        end
      endcase
      vd3  <= vd_d[NS];
      vq3  <= vq_d[NS];
      udc3 <= udc_d[NS];
    end
  end

  // inverse park
  logic signed [svpwm_pkg::P_W-1:0]   p_cd, p_sq, p_sd, p_cq;
  logic [15:0]                        udc4, udc5, udc6, udc7;
  logic signed [svpwm_pkg::P_W:0]     sum_x, sum_y;
  logic signed [svpwm_pkg::UXY_W-1:0] ux5, uy5;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_cd <= c3 * vd3;
      p_sq <= s3 * vq3;
      p_sd <= s3 * vd3;
      p_cq <= c3 * vq3;
      udc4 <= udc3;
    end
  end

  always_comb begin
    sum_x = (svpwm_pkg::P_W+1)'(p_cd) - (svpwm_pkg::P_W+1)'(p_sq);
    sum_y = (svpwm_pkg::P_W+1)'(p_sd) + (svpwm_pkg::P_W+1)'(p_cq);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ux5  <= svpwm_pkg::UXY_W'(sum_x >>> 14);
      uy5  <= svpwm_pkg::UXY_W'(sum_y >>> 14);
      udc5 <= udc4;
    end
  end

  // inverse clarke
  logic signed [52:0]               pa6, pb6;
  logic signed [svpwm_pkg::U_W-1:0] u1_6;
  logic signed [53:0]               d2, d3;
  logic signed [svpwm_pkg::U_W-1:0] u1_7, u2_7, u3_7;

  always_ff @(posedge clk) begin
    if (ce) begin
      pa6  <= ux5 * $signed({1'b0, svpwm_pkg::K_0866});
      pb6  <= 53'(uy5) <<< 15;
      u1_6 <= svpwm_pkg::U_W'(uy5);
      udc6 <= udc5;
    end
  end

  always_comb begin
    d2 = 54'(pa6) - 54'(pb6);
    d3 = -54'(pa6) - 54'(pb6);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      u1_7 <= u1_6;
      u2_7 <= svpwm_pkg::U_W'(d2 >>> 16);
      u3_7 <= svpwm_pkg::U_W'(d3 >>> 16);
      udc7 <= udc6;
    end
  end

  // sector and the two active vector magnitudes
  logic [2:0]                       code7, sec7;
  logic signed [svpwm_pkg::U_W-1:0] n1, n2, n3;
  logic [svpwm_pkg::TV_W-1:0]       txv7, tyv7, tx8, ty8;
  logic [15:0]                      udc8;
  svpwm_pkg::side_t                 side8;

  always_comb begin
    code7 = {u3_7 > 0, u2_7 > 0, u1_7 > 0};
    sec7  = svpwm_pkg::sector_of_code(code7);
    n1    = -u1_7;
    n2    = -u2_7;
    n3    = -u3_7;
    case (sec7)
      3'd1: begin
        txv7 = u2_7;
        tyv7 = u1_7;
      end
      3'd2: begin
        txv7 = n2;
        tyv7 = n3;
      end
      3'd3: begin
        txv7 = u1_7;
        tyv7 = u3_7;
      end
      3'd4: begin
        txv7 = n1;
        tyv7 = n2;
      end
      3'd5: begin
        txv7 = u3_7;
        tyv7 = u2_7;
      end
      default: begin
        txv7 = n3;
        tyv7 = n1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tx8            <= txv7;
      ty8            <= tyv7;
      udc8           <= udc7;
      side8.sector   <= sec7;
      side8.zero_vec <= (sec7 == 3'd0);
      side8.udc_zero <= (udc7 == 16'd0);
    end
  end

  // scaled numerators; den = udc << (32 - DUTY_BITS) folds into the shift
  logic [53:0]      mx, my;
  logic [15:0]      dx_den [0:QW];
  logic [15:0]      dy_den [0:QW];
  logic [15:0]      rx     [0:QW];
  logic [15:0]      ry     [0:QW];
  logic [QW-1:0]    nqx    [0:QW];
  logic [QW-1:0]    nqy    [0:QW];
  svpwm_pkg::side_t side_d [0:QW];

  always_comb begin
    mx = tx8 * svpwm_pkg::K_1732;
    my = ty8 * svpwm_pkg::K_1732;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nqx[0]    <= QW'(mx >> (32 - DUTY_BITS));
      nqy[0]    <= QW'(my >> (32 - DUTY_BITS));
      rx[0]     <= '0;
      ry[0]     <= '0;
      dx_den[0] <= udc8;
      dy_den[0] <= udc8;
      side_d[0] <= side8;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    svpwm_div_cell #(.QW(QW)) u_div_x (
      .clk     (clk),
      .ce      (ce),
      .den_in  (dx_den[k]),
      .rem_in  (rx[k]),
      .nq_in   (nqx[k]),
      .den_out (dx_den[k+1]),
      .rem_out (rx[k+1]),
      .nq_out  (nqx[k+1])
    );

    svpwm_div_cell #(.QW(QW)) u_div_y (
      .clk     (clk),
      .ce      (ce),
      .den_in  (dy_den[k]),
      .rem_in  (ry[k]),
      .nq_in   (nqy[k]),
      .den_out (dy_den[k+1]),
      .rem_out (ry[k+1]),
      .nq_out  (nqy[k+1])
    );

    always_ff @(posedge clk) begin
      if (ce) begin
        side_d[k+1] <= side_d[k];
      end
    end
  end

  // segment times
  logic signed [TW-1:0] txs, tys;
  logic signed [TW-1:0] t_s [0:2];
  svpwm_pkg::side_t     side10;

  assign txs = $signed({3'b000, nqx[QW]});
  assign tys = $signed({3'b000, nqy[QW]});

  always_ff @(posedge clk) begin
    if (ce) begin
      t_s[0] <= (ONE - txs - tys) >>> 1;
      t_s[1] <= (ONE + txs - tys) >>> 1;
      t_s[2] <= (ONE + txs + tys) >>> 1;
      side10 <= side_d[QW];
    end
  end

  // clip, convert to q0.16 and route to phases
  logic [15:0]          d_q [0:2];
  logic [2:0]           clip;
  logic signed [TW-1:0] tv;
  logic [TW-1:0]        tsh;
  logic [1:0]           pick_a, pick_b, pick_c;
  logic [15:0]          duty_a, duty_b, duty_c;
  logic [2:0]           sector_o;
  logic                 sat_o;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip[k] = 1'b0;
      tv      = t_s[k];
      if (tv < 0) begin
        tv      = '0;
        clip[k] = 1'b1;
      end else if (tv > ONE) begin
        tv      = ONE;
        clip[k] = 1'b1;
      end
      tsh    = (tv >> SH_R) << SH_L;
      d_q[k] = (tv == ONE) ? 16'hFFFF : tsh[15:0];
    end
    case (side10.sector)
      3'd1: begin pick_a = 2'd0; pick_b = 2'd1; pick_c = 2'd2; end
      3'd2: begin pick_a = 2'd1; pick_b = 2'd0; pick_c = 2'd2; end
      3'd3: begin pick_a = 2'd2; pick_b = 2'd0; pick_c = 2'd1; end
      3'd4: begin pick_a = 2'd2; pick_b = 2'd1; pick_c = 2'd0; end
      3'd5: begin pick_a = 2'd1; pick_b = 2'd2; pick_c = 2'd0; end
      default: begin pick_a = 2'd0; pick_b = 2'd2; pick_c = 2'd1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (side10.zero_vec || side10.udc_zero) begin
        duty_a   <= 16'h8000;
        duty_b   <= 16'h8000;
        duty_c   <= 16'h8000;
        sector_o <= side10.zero_vec ? 3'd1 : side10.sector;
        sat_o    <= side10.udc_zero;
      end else begin
        duty_a   <= d_q[pick_a];
        duty_b   <= d_q[pick_b];
        duty_c   <= d_q[pick_c];
        sector_o <= side10.sector;
        sat_o    <= |clip;
      end
    end
  end

  assign m_tdata = {4'h0, sat_o, sector_o, duty_c, duty_b, duty_a};

endmodule

// ===== rtl/core/svpwm_checker.sv =====
// ----------------------------------------------------------------------------
// svpwm_checker
// port-level checks of the duty generator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svpwm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
  `ASSERT_CLK(a_sector_range, m_tvalid |-> (m_tdata[50:48] != 3'd0 && m_tdata[50:48] != 3'd7), "sector out of range")
  `ASSERT_CLK(a_stall_blocks_in, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result after reset")

endmodule

bind svpwm_duty_generator_core svpwm_checker u_svpwm_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives angle/voltage/bus items into the svpwm duty core under several pole
// pair settings. A bit-accurate duty predictor computes the expected duties,
// sector and saturation flag, which are compared in order with each output
// transfer. Sender gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = svpwm_pkg::CORDIC_STAGES_DEF + svpwm_pkg::DUTY_BITS_DEF + 33;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  logic [63:0] pending_items[$];
  logic [55:0] expected_duties[$];
  logic [6:0]  model_pole_pairs = svpwm_pkg::POLE_PAIRS_RST;
  int          n_accepted = 0;
  int          n_popped = 0;
  int          n_errors = 0;
  int          idle_cycles = 0;

  svpwm_duty_generator_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  localparam longint ATAN_TURN[16] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D
  };

  function automatic longint floor_quot(input longint n, input longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // expected output word: duty_a, duty_b, duty_c, sector, saturated
  function automatic logic [55:0] predict_duties(input logic [63:0] item,
                                                 input logic [6:0] pp);
    logic [22:0] prod;
    logic [31:0] z, q, rw;
    logic [2:0]  code, sector;
    logic        sat;
    longint r, x, y, dx, dy, s, c, vd, vq, udc, ux, uy, u1, u2, u3;
    longint txv, tyv, tx, ty, den, t0, t1, t2;
    longint duty[3];
    prod = item[15:0] * pp;
    z = {prod[15:0], 16'h0};
    q = ((z + 32'h2000_0000) >> 30) & 32'd3;
    rw = z - (q << 30);
    r = longint'($signed(rw));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; r += ATAN_TURN[i];
      end
    end
    case (q[1:0])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    vd = longint'($signed(item[31:16]));
    vq = longint'($signed(item[47:32]));
    udc = longint'(item[63:48]);
    ux = (c * vd - s * vq) >>> 14;
    uy = (s * vd + c * vq) >>> 14;
    u1 = uy;
    u2 = (ux * 56754 - uy * 32768) >>> 16;
    u3 = (-ux * 56754 - uy * 32768) >>> 16;
    code = {u3 > 0, u2 > 0, u1 > 0};
    case (code)
      3'd1: sector = 3'd2;
      3'd2: sector = 3'd6;
      3'd3: sector = 3'd1;
      3'd4: sector = 3'd4;
      3'd5: sector = 3'd3;
      3'd6: sector = 3'd5;
      default: sector = 3'd0;
    endcase
    if (sector == 3'd0 || udc == 0)
      return {4'h0, udc == 0, (sector == 3'd0) ? 3'd1 : sector,
              16'd32768, 16'd32768, 16'd32768};
    case (sector)
      3'd1: begin txv = u2; tyv = u1; end
      3'd2: begin txv = -u2; tyv = -u3; end
      3'd3: begin txv = u1; tyv = u3; end
      3'd4: begin txv = -u1; tyv = -u2; end
      3'd5: begin txv = u3; tyv = u2; end
      default: begin txv = -u3; tyv = -u1; end
    endcase
    den = udc <<< 16;
    tx = floor_quot(txv * 113508, den);
    ty = floor_quot(tyv * 113508, den);
    t0 = (65536 - tx - ty) >>> 1;
    t1 = (65536 + tx - ty) >>> 1;
    t2 = (65536 + tx + ty) >>> 1;
    // which of t0..t2 drives each phase
    case (sector)
      3'd1: duty = '{t0, t1, t2};
      3'd2: duty = '{t1, t0, t2};
      3'd3: duty = '{t2, t0, t1};
      3'd4: duty = '{t2, t1, t0};
      3'd5: duty = '{t1, t2, t0};
      default: duty = '{t0, t2, t1};
    endcase
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (duty[k] < 0) begin duty[k] = 0; sat = 1'b1; end
      else if (duty[k] > 65536) begin duty[k] = 65536; sat = 1'b1; end
      if (duty[k] > 65535) duty[k] = 65535;
    end
    return {4'h0, sat, sector, duty[2][15:0], duty[1][15:0], duty[0][15:0]};
  endfunction

  // input acceptance, output checking, watchdog
  always @(posedge clk) begin
    logic [55:0] exp_word;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_duties.push_back(predict_duties(s_tdata, model_pole_pairs));
        n_accepted <= n_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_duties.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected output transfer %h", m_tdata);
        end else begin
          exp_word = expected_duties.pop_front();
          if (m_tdata[15:0] !== exp_word[15:0] || m_tdata[31:16] !== exp_word[31:16] ||
              m_tdata[47:32] !== exp_word[47:32] || m_tdata[50:48] !== exp_word[50:48] ||
              m_tdata[51] !== exp_word[51]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected a=%0d b=%0d c=%0d sec=%0d sat=%0d, got a=%0d b=%0d c=%0d sec=%0d sat=%0d",
                       exp_word[15:0], exp_word[31:16], exp_word[47:32], exp_word[50:48],
                       exp_word[51], m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                       m_tdata[50:48], m_tdata[51]);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    logic        nxt_valid;
    logic [63:0] nxt_data;
    logic        hold;
    nxt_valid = 1'b0;
    nxt_data = s_tdata;
    hold = 1'b0;
    if (n_accepted > n_popped) begin
      void'(pending_items.pop_front());
      n_popped <= n_popped + 1;
    end else if (s_tvalid) begin
      // offered item not taken yet, keep it on the bus
      hold = 1'b1;
    end
    if (hold) begin
      nxt_valid = 1'b1;
      nxt_data = s_tdata;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_items.size() > 0) begin
      nxt_valid = 1'b1;
      nxt_data = pending_items[0];
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata <= nxt_data;
  end

  // receiver: stall mode and pattern are redrawn whenever the mode count runs out
  int stall_mode = 0;
  int mode_cycles = 0;
  logic [7:0] stall_pattern = 8'hA5;
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_pattern = 8'($urandom) | 8'h01;
      mode_cycles = $urandom_range(50, 300);
    end else begin
      mode_cycles--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= stall_pattern[mode_cycles % 8];
    endcase
  end

  function automatic logic [63:0] pack_item(input logic [15:0] ang, input logic [15:0] vd,
                                            input logic [15:0] vq, input logic [15:0] bus);
    return {bus, vq, vd, ang};
  endfunction

  task automatic write_pole_pairs(input logic [6:0] value);
    wait (expected_duties.size() == 0 && pending_items.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    model_pole_pairs = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_items(input int count);
    logic [15:0] vd, vq, bus;
    int sh;
    for (int i = 0; i < count; i++) begin
      sh = $urandom_range(0, 15);
      vd = 16'($signed(16'($urandom)) >>> sh);
      vq = 16'($signed(16'($urandom)) >>> sh);
      case ($urandom_range(0, 9))
        0: bus = 16'd0;
        1: bus = 16'($urandom_range(1, 255));
        2: bus = 16'hFFFF;
        default: bus = 16'($urandom);
      endcase
      pending_items.push_back(pack_item(16'($urandom), vd, vq, bus));
    end
  endtask

  logic [6:0] pole_settings[6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd0};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, zero vector, zero bus, saturation
    pending_items.push_back(pack_item(16'h0000, 16'h0000, 16'h0000, 16'd1000));
    pending_items.push_back(pack_item(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    pending_items.push_back(pack_item(16'h0000, 16'h8000, 16'h8000, 16'hFFFF));
    pending_items.push_back(pack_item(16'h4000, 16'h7FFF, 16'h8000, 16'd1));
    pending_items.push_back(pack_item(16'h8000, 16'h0100, 16'h0200, 16'd0));
    pending_items.push_back(pack_item(16'h1234, 16'h0000, 16'h0000, 16'd0));
    pending_items.push_back(pack_item(16'hC000, 16'h0400, 16'hFC00, 16'd20000));
    pending_items.push_back(pack_item(16'h2AAA, 16'h0000, 16'h1000, 16'd8000));
    pending_items.push_back(pack_item(16'h5555, 16'hF000, 16'h0000, 16'd8000));
    pending_items.push_back(pack_item(16'hAAAA, 16'h0800, 16'h0800, 16'h8000));
    pending_items.push_back(pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF));
    for (int k = 0; k < 8; k++)
      pending_items.push_back(pack_item(16'(k * 1560), 16'h0000, 16'h2000, 16'd12000));
    queue_random_items(PHASE_ITEMS - 19);
    foreach (pole_settings[p]) begin
      write_pole_pairs(pole_settings[p] == 7'd0 && p == 5 ? 7'($urandom_range(2, 63))
                                                          : pole_settings[p]);
      queue_random_items(PHASE_ITEMS - 100);
    end
    wait (pending_items.size() == 0 && expected_duties.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && expected_duties.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
